/* rtl/tesq_pkg.sv */
// Shared types and constants for the timed event scheduler queue.
// Used by the queue cell and the top level; depends on nothing else.
package tesq_pkg;

  localparam int QueueDepth = 16;
  localparam int IdxW = $clog2(QueueDepth);
  localparam int TagW = 4;
  localparam int CmpW = (IdxW > TagW) ? IdxW : TagW;
  localparam int DateW = 48;
  localparam int CbW = 16;
  localparam int CtxW = 32;
  localparam int StepW = 32;
  localparam int MaxResults = 16;
  localparam int NumW = $clog2(MaxResults + 1);
  localparam int BitCntW = $clog2(DateW);
  localparam logic [DateW-1:0] DateMax = {DateW{1'b1}};

  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_REMOVE = 2'd1,
    OP_TICK   = 2'd2,
    OP_NONE   = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    K_ADDED       = 3'd0,
    K_FULL        = 3'd1,
    K_REMOVED     = 3'd2,
    K_NOT_PENDING = 3'd3,
    K_FIRED       = 3'd4
  } kind_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_ROUND,
    S_SCAN,
    S_DONE
  } state_e;

  typedef struct packed {
    op_e              op;
    logic [DateW-1:0] now;
    logic [TagW-1:0]  tag;
  } scan_t;

  typedef struct packed {
    logic             hit;
    logic [IdxW-1:0]  hidx;
    logic [DateW-1:0] hdate;
    logic [CbW-1:0]   hcb;
    logic [CtxW-1:0]  hctx;
    logic             free_found;
    logic [IdxW-1:0]  free_idx;
  } tok_t;

endpackage

/* rtl/tesq_cell.sv */
// One queue slot: holds an entry and updates the search request passing through.
// Depends on tesq_pkg.
module tesq_cell (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic [tesq_pkg::IdxW-1:0] idx_i,
  input  tesq_pkg::scan_t           scan_i,
  input  tesq_pkg::tok_t            tok_i,
  output tesq_pkg::tok_t            tok_o,
  input  logic                      wr_i,
  input  logic                      clr_i,
  input  logic [tesq_pkg::DateW-1:0] wdate_i,
  input  logic [tesq_pkg::CbW-1:0]  wcb_i,
  input  logic [tesq_pkg::CtxW-1:0] wctx_i
);
  import tesq_pkg::*;

  logic             valid_q;
  logic [DateW-1:0] date_q;
  logic [CbW-1:0]   cb_q;
  logic [CtxW-1:0]  ctx_q;
  tok_t             tok_d, tok_q;
  logic             take;

  always_comb begin
    take = 1'b0;
    unique case (scan_i.op)
      OP_REMOVE: take = valid_q && (CmpW'(idx_i) == CmpW'(scan_i.tag));
      OP_TICK:   take = valid_q && (date_q <= scan_i.now) &&
                        (!tok_i.hit || (date_q < tok_i.hdate));
      default:   take = 1'b0;
    endcase
    tok_d = tok_i;
    if (take) begin
      tok_d.hit   = 1'b1;
      tok_d.hidx  = idx_i;
      tok_d.hdate = date_q;
      tok_d.hcb   = cb_q;
      tok_d.hctx  = ctx_q;
    end
    if (!valid_q && !tok_i.free_found) begin
      tok_d.free_found = 1'b1;
      tok_d.free_idx   = idx_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      tok_q   <= '0;
    end else begin
      tok_q <= tok_d;
      if (wr_i) begin
        valid_q <= 1'b1;
      end else if (clr_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i) begin
      date_q <= wdate_i;
      cb_q   <= wcb_i;
      ctx_q  <= wctx_i;
    end
  end

  assign tok_o = tok_q;

endmodule

/* rtl/timed_event_scheduler_queue_top.sv */
// Top level of the timed event scheduler queue: controller, rounding divider
// and the row of tesq_cell slots. Depends on tesq_pkg and tesq_cell.
//
//   channel   signals                                   handshake
//   request   mode, due_time, callback_id, context, tag start_i && !busy_o
//   result    kind, tag, callback, context, date, last  result_valid_o, one cycle
//   config    cfg_we_i, cfg_data_i (round_step)         cfg_we_i, while idle
//
// Each add, remove or tick request scans the row of slots. An add with a
// nonzero round_step first runs a bit-serial remainder over the 48 date bits,
// then rounds the due time up. A tick rescans once per fired entry (at most
// MaxResults) plus one final scan. Reset empties all slots and clears round_step.
// Results cannot be stalled by the receiver.
module timed_event_scheduler_queue_top (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  output logic                         busy_o,
  input  logic [1:0]                   mode_i,
  input  logic [tesq_pkg::DateW-1:0]   due_time_i,
  input  logic [tesq_pkg::CbW-1:0]     callback_id_i,
  input  logic [tesq_pkg::CtxW-1:0]    context_word_i,
  input  logic [tesq_pkg::TagW-1:0]    slot_tag_i,
  input  logic                         cfg_we_i,
  input  logic [tesq_pkg::StepW-1:0]   cfg_data_i,
  output logic                         result_valid_o,
  output logic [2:0]                   kind_o,
  output logic [tesq_pkg::TagW-1:0]    out_tag_o,
  output logic [tesq_pkg::CbW-1:0]     out_callback_o,
  output logic [tesq_pkg::CtxW-1:0]    out_context_o,
  output logic [tesq_pkg::DateW-1:0]   out_date_o,
  output logic                         last_o
);
  import tesq_pkg::*;

  state_e state_q, state_d;
  logic [StepW-1:0] step_q;
  scan_t            scan_q;
  logic [DateW-1:0] rdate_q, rdate_d;
  logic [CbW-1:0]   cb_q;
  logic [CtxW-1:0]  ctx_q;
  logic [StepW:0]   rem_q, rem_d;
  logic [BitCntW-1:0] bit_q;
  logic [IdxW-1:0]  cnt_q;
  logic [NumW-1:0]  num_q;
  tok_t             pend_q;
  logic             pend_valid_q;
  tok_t             tok [QueueDepth+1];
  logic [QueueDepth-1:0] wr_vec, clr_vec;
  logic             accept, hit, fire_more;
  logic [StepW:0]   rem_sh;
  logic [DateW:0]   sum;

  logic             res_v_d, res_v_q, res_last_d, res_last_q;
  kind_e            res_kind_d, res_kind_q;
  logic [TagW-1:0]  res_tag_d, res_tag_q;
  logic [CbW-1:0]   res_cb_d, res_cb_q;
  logic [CtxW-1:0]  res_ctx_d, res_ctx_q;
  logic [DateW-1:0] res_date_d, res_date_q;

  assign accept    = start_i && (state_q == S_IDLE);
  assign hit       = tok[QueueDepth].hit;
  assign fire_more = hit && (num_q < NumW'(MaxResults));
  assign rem_sh    = {rem_q[StepW-1:0], rdate_q[bit_q]};
  assign rem_d     = (rem_sh >= {1'b0, step_q}) ? rem_sh - {1'b0, step_q} : rem_sh;
  assign sum       = {1'b0, rdate_q} + {{(DateW-StepW){1'b0}}, 1'b0, step_q}
                   - {{(DateW-StepW){1'b0}}, rem_q};
  assign rdate_d   = (rem_q == '0) ? rdate_q :
                     (sum[DateW] ? DateMax : sum[DateW-1:0]);

  assign tok[0] = '0;

  for (genvar k = 0; k < QueueDepth; k++) begin : g_cell
    tesq_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .idx_i   (IdxW'(k)),
      .scan_i  (scan_q),
      .tok_i   (tok[k]),
      .tok_o   (tok[k+1]),
      .wr_i    (wr_vec[k]),
      .clr_i   (clr_vec[k]),
      .wdate_i (rdate_q),
      .wcb_i   (cb_q),
      .wctx_i  (ctx_q)
    );
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (op_e'(mode_i) == OP_NONE) begin
            state_d = S_IDLE;
          end else if (op_e'(mode_i) == OP_ADD && step_q != '0) begin
            state_d = S_DIV;
          end else begin
            state_d = S_SCAN;
          end
        end
      end
      S_DIV:   if (bit_q == '0) state_d = S_ROUND;
      S_ROUND: state_d = S_SCAN;
      S_SCAN:  if (cnt_q == IdxW'(QueueDepth - 1)) state_d = S_DONE;
      S_DONE: begin
        if (scan_q.op == OP_TICK && fire_more) begin
          state_d = S_SCAN;
        end else begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    wr_vec     = '0;
    clr_vec    = '0;
    res_v_d    = 1'b0;
    res_kind_d = K_ADDED;
    res_tag_d  = '0;
    res_cb_d   = '0;
    res_ctx_d  = '0;
    res_date_d = '0;
    res_last_d = 1'b1;
    if (state_q == S_DONE) begin
      unique case (scan_q.op)
        OP_ADD: begin
          res_v_d    = 1'b1;
          res_date_d = rdate_q;
          if (tok[QueueDepth].free_found) begin
            wr_vec[tok[QueueDepth].free_idx] = 1'b1;
            res_tag_d = TagW'(CmpW'(tok[QueueDepth].free_idx));
          end else begin
            res_kind_d = K_FULL;
          end
        end
        OP_REMOVE: begin
          res_v_d = 1'b1;
          if (hit) begin
            clr_vec[tok[QueueDepth].hidx] = 1'b1;
            res_kind_d = K_REMOVED;
            res_tag_d  = TagW'(CmpW'(tok[QueueDepth].hidx));
            res_date_d = tok[QueueDepth].hdate;
          end else begin
            res_kind_d = K_NOT_PENDING;
            res_tag_d  = scan_q.tag;
          end
        end
        OP_TICK: begin
          if (fire_more) begin
            clr_vec[tok[QueueDepth].hidx] = 1'b1;
          end
          res_v_d    = pend_valid_q;
          res_kind_d = K_FIRED;
          res_tag_d  = TagW'(CmpW'(pend_q.hidx));
          res_cb_d   = pend_q.hcb;
          res_ctx_d  = pend_q.hctx;
          res_date_d = pend_q.hdate;
          res_last_d = !fire_more;
        end
        default: res_v_d = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      step_q       <= '0;
      scan_q       <= '{op: OP_NONE, default: '0};
      cnt_q        <= '0;
      num_q        <= '0;
      bit_q        <= '0;
      pend_valid_q <= 1'b0;
      res_v_q      <= 1'b0;
    end else begin
      state_q <= state_d;
      res_v_q <= res_v_d;
      if (cfg_we_i) begin
        step_q <= cfg_data_i;
      end
      if (accept) begin
        scan_q.op    <= op_e'(mode_i);
        scan_q.now   <= due_time_i;
        scan_q.tag   <= slot_tag_i;
        bit_q        <= BitCntW'(DateW - 1);
        num_q        <= '0;
        pend_valid_q <= 1'b0;
      end
      if (state_q == S_DIV) begin
        bit_q <= bit_q - 1'b1;
      end
      if (state_q == S_SCAN) begin
        cnt_q <= cnt_q + 1'b1;
      end else begin
        cnt_q <= '0;
      end
      if (state_q == S_DONE && scan_q.op == OP_TICK) begin
        pend_valid_q <= fire_more;
        if (fire_more) begin
          num_q <= num_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      rdate_q <= due_time_i;
      cb_q    <= callback_id_i;
      ctx_q   <= context_word_i;
      rem_q   <= '0;
    end
    if (state_q == S_DIV) begin
      rem_q <= rem_d;
    end
    if (state_q == S_ROUND) begin
      rdate_q <= rdate_d;
    end
    if (state_q == S_DONE) begin
      pend_q <= tok[QueueDepth];
    end
    res_kind_q <= res_kind_d;
    res_tag_q  <= res_tag_d;
    res_cb_q   <= res_cb_d;
    res_ctx_q  <= res_ctx_d;
    res_date_q <= res_date_d;
    res_last_q <= res_last_d;
  end

  assign busy_o         = (state_q != S_IDLE);
  assign result_valid_o = res_v_q;
  assign kind_o         = res_kind_q;
  assign out_tag_o      = res_tag_q;
  assign out_callback_o = res_cb_q;
  assign out_context_o  = res_ctx_q;
  assign out_date_o     = res_date_q;
  assign last_o         = res_last_q;

endmodule
